### rtl/message_header_validator_unit_macros.svh
`ifndef MESSAGE_HEADER_VALIDATOR_UNIT_MACROS_SVH
`define MESSAGE_HEADER_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset
`define MHV_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MHV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mhv_pkg.sv
`timescale 1ns / 1ps

package mhv_pkg;

   localparam int HEADER_BYTES = 24;
   localparam int HDR_W        = 8 * HEADER_BYTES;
   localparam int CNT_W        = $clog2(HEADER_BYTES + 1);
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   localparam logic [2:0] REG_MAGIC_WORD       = 3'd0;
   localparam logic [2:0] REG_PROTOCOL_VERSION = 3'd1;
   localparam logic [2:0] REG_TYPE_MIN         = 3'd2;
   localparam logic [2:0] REG_TYPE_MAX         = 3'd3;
   localparam logic [2:0] REG_METADATA_LIMIT   = 3'd4;
   localparam logic [2:0] REG_BODY_LIMIT       = 3'd5;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_TRUNCATED,
      STATUS_BAD_MAGIC,
      STATUS_BAD_VERSION,
      STATUS_UNKNOWN_TYPE,
      STATUS_META_BIG,
      STATUS_BODY_BIG
   } status_type;

   // Header in wire order, first byte in the top bits
   typedef struct packed {
      logic [31:0] magic;
      logic [15:0] version;
      logic [15:0] msg_type;
      logic [31:0] flags;
      logic [31:0] request_id;
      logic [31:0] metadata_length;
      logic [31:0] body_length;
   } hdr_type;

   typedef struct packed {
      logic    truncated;
      hdr_type hdr;
   } rec_type;

   typedef struct packed {
      logic [31:0] magic_word;
      logic [15:0] protocol_version;
      logic [15:0] type_min;
      logic [15:0] type_max;
      logic [31:0] metadata_limit;
      logic [31:0] body_limit;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] version;
      logic [15:0] msg_type;
      logic [31:0] flags;
      logic [31:0] request_id;
      logic [31:0] metadata_length;
      logic [31:0] body_length;
   } rsp_type;

endpackage

### rtl/mhv_fifo.sv
`timescale 1ns / 1ps

module mhv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### rtl/mhv_front.sv
`timescale 1ns / 1ps

module mhv_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             last,
   output logic             rec_push,
   output mhv_pkg::rec_type rec
);

   logic [mhv_pkg::HDR_W-1:0] hdr_ff, hdr_in;
   logic [mhv_pkg::CNT_W-1:0] cnt_ff, cnt_in, cnt_inc;
   logic                      room;

   assign room = (cnt_ff < mhv_pkg::CNT_W'(mhv_pkg::HEADER_BYTES));

   always_comb begin
      hdr_in   = hdr_ff;
      cnt_inc  = cnt_ff;
      cnt_in   = cnt_ff;
      rec_push = 1'b0;
      if (accept && room) begin
         // shift in, first byte ends up at the top of the header
         hdr_in  = {hdr_ff[mhv_pkg::HDR_W-9:0], data_byte};
         cnt_inc = cnt_ff + mhv_pkg::CNT_W'(1);
      end
      if (accept) begin
         cnt_in = cnt_inc;
         if (last) begin
            rec_push = 1'b1;
            cnt_in   = '0;
         end
      end
      rec.truncated = (cnt_inc < mhv_pkg::CNT_W'(mhv_pkg::HEADER_BYTES));
      rec.hdr       = hdr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

endmodule

### rtl/mhv_back.sv
`timescale 1ns / 1ps

module mhv_back (
   input  logic             rec_valid,
   input  mhv_pkg::rec_type rec,
   output logic             rec_pop,
   input  mhv_pkg::cfg_type cfg,
   input  logic             rsp_full,
   output logic             rsp_push,
   output mhv_pkg::rsp_type rsp
);

   mhv_pkg::status_type status;

   always_comb begin
      if (rec.truncated) begin
         status = mhv_pkg::STATUS_TRUNCATED;
      end else if (rec.hdr.magic != cfg.magic_word) begin
         status = mhv_pkg::STATUS_BAD_MAGIC;
      end else if (rec.hdr.version != cfg.protocol_version) begin
         status = mhv_pkg::STATUS_BAD_VERSION;
      end else if (rec.hdr.msg_type < cfg.type_min || rec.hdr.msg_type > cfg.type_max) begin
         status = mhv_pkg::STATUS_UNKNOWN_TYPE;
      end else if (rec.hdr.metadata_length > cfg.metadata_limit) begin
         status = mhv_pkg::STATUS_META_BIG;
      end else if (rec.hdr.body_length > cfg.body_limit) begin
         status = mhv_pkg::STATUS_BODY_BIG;
      end else begin
         status = mhv_pkg::STATUS_OK;
      end
   end

   always_comb begin
      rsp        = '0;
      rsp.status = status;
      // drop the decoded fields unless the header passed every check
      if (status == mhv_pkg::STATUS_OK) begin
         rsp.version         = rec.hdr.version;
         rsp.msg_type        = rec.hdr.msg_type;
         rsp.flags           = rec.hdr.flags;
         rsp.request_id      = rec.hdr.request_id;
         rsp.metadata_length = rec.hdr.metadata_length;
         rsp.body_length     = rec.hdr.body_length;
      end
   end

   assign rsp_push = rec_valid & ~rsp_full;
   assign rec_pop  = rsp_push;

endmodule

### rtl/message_header_validator_unit.sv
`timescale 1ns / 1ps
`include "message_header_validator_unit_macros.svh"

// Message header validator. Takes one message byte per clock while full is low,
// on push/full, with req_last on the final byte, and gives one status item per
// message on empty/pop. The first 24 bytes form a big-endian header; later
// bytes are ignored. The record queue takes a message's record at the clock edge
// that takes its final byte; the checker then writes its status into the output
// queue, which drives the result ports, once that queue has room. The sustained
// rate is one byte per cycle while full is low, set by the header shift register
// and byte counter in the front end. Final-byte records cross to the checker
// through a QUEUE_DEPTH-entry queue and results wait in a QUEUE_DEPTH-entry
// output queue, so full rises only while those are both backed up.
// Registers (APB, 4-byte stride): 0 magic word, 1 protocol version, 2 type
// min, 3 type max, 4 metadata limit, 5 body limit. Change them only while idle.
module message_header_validator_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_last,
   output logic                           empty,
   input  logic                           pop,
   output logic [2:0]                     rsp_status,
   output logic [15:0]                    rsp_version,
   output logic [15:0]                    rsp_msg_type,
   output logic [31:0]                    rsp_flags,
   output logic [31:0]                    rsp_request_id,
   output logic [31:0]                    rsp_metadata_length,
   output logic [31:0]                    rsp_body_length,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mhv_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mhv_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mhv_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   mhv_pkg::cfg_type cfg_ff, cfg_in;
   mhv_pkg::rec_type front_rec, back_rec;
   mhv_pkg::rsp_type back_rsp, out_rsp;
   logic [2:0]       reg_idx;
   logic             csr_write;
   logic             accept;
   logic             rec_push, rec_pop, q_full, q_empty;
   logic             rsp_push, out_full;

   // configuration registers
   assign pready    = 1'b1;
   assign reg_idx   = paddr[4:2];
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_idx)
            mhv_pkg::REG_MAGIC_WORD:       cfg_in.magic_word       = pwdata;
            mhv_pkg::REG_PROTOCOL_VERSION: cfg_in.protocol_version = pwdata[15:0];
            mhv_pkg::REG_TYPE_MIN:         cfg_in.type_min         = pwdata[15:0];
            mhv_pkg::REG_TYPE_MAX:         cfg_in.type_max         = pwdata[15:0];
            mhv_pkg::REG_METADATA_LIMIT:   cfg_in.metadata_limit   = pwdata;
            mhv_pkg::REG_BODY_LIMIT:       cfg_in.body_limit       = pwdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mhv_pkg::REG_MAGIC_WORD:       prdata = cfg_ff.magic_word;
         mhv_pkg::REG_PROTOCOL_VERSION: prdata = {16'd0, cfg_ff.protocol_version};
         mhv_pkg::REG_TYPE_MIN:         prdata = {16'd0, cfg_ff.type_min};
         mhv_pkg::REG_TYPE_MAX:         prdata = {16'd0, cfg_ff.type_max};
         mhv_pkg::REG_METADATA_LIMIT:   prdata = cfg_ff.metadata_limit;
         mhv_pkg::REG_BODY_LIMIT:       prdata = cfg_ff.body_limit;
         default:                       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word       <= 32'd0;
         cfg_ff.protocol_version <= 16'd1;
         cfg_ff.type_min         <= 16'd1;
         cfg_ff.type_max         <= 16'd1;
         cfg_ff.metadata_limit   <= 32'd0;
         cfg_ff.body_limit       <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: collect header bytes
   assign full   = q_full;
   assign accept = push & ~full;

   mhv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last      (req_last),
      .rec_push  (rec_push),
      .rec       (front_rec)
   );

   mhv_fifo #(
      .WIDTH ($bits(mhv_pkg::rec_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rec_queue (
      .clock (clock),
      .reset (reset),
      .push  (rec_push),
      .wdata (front_rec),
      .full  (q_full),
      .pop   (rec_pop),
      .rdata (back_rec),
      .empty (q_empty)
   );

   // back end: run the checks
   mhv_back u_back (
      .rec_valid (~q_empty),
      .rec       (back_rec),
      .rec_pop   (rec_pop),
      .cfg       (cfg_ff),
      .rsp_full  (out_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   mhv_fifo #(
      .WIDTH ($bits(mhv_pkg::rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (back_rsp),
      .full  (out_full),
      .pop   (pop),
      .rdata (out_rsp),
      .empty (empty)
   );

   assign rsp_status          = out_rsp.status;
   assign rsp_version         = out_rsp.version;
   assign rsp_msg_type        = out_rsp.msg_type;
   assign rsp_flags           = out_rsp.flags;
   assign rsp_request_id      = out_rsp.request_id;
   assign rsp_metadata_length = out_rsp.metadata_length;
   assign rsp_body_length     = out_rsp.body_length;

   `MHV_ASSERT_NOW(a_fields_zero_on_error,
      !empty && rsp_status != mhv_pkg::STATUS_OK,
      rsp_version == 16'd0 && rsp_msg_type == 16'd0 && rsp_flags == 32'd0 &&
      rsp_request_id == 32'd0 && rsp_metadata_length == 32'd0 && rsp_body_length == 32'd0,
      "decoded fields not zero on error status")
   `MHV_ASSERT_NEXT(a_last_reaches_queue, accept && req_last, !q_empty,
      "final byte left no record in the queue")
   `MHV_ASSERT_NOW(a_ok_within_limits,
      !empty && rsp_status == mhv_pkg::STATUS_OK,
      rsp_metadata_length <= cfg_ff.metadata_limit && rsp_body_length <= cfg_ff.body_limit,
      "ok status with a length over its limit")

endmodule

### bench/message_header_validator_unit_test.sv
`timescale 1ns / 1ps

module message_header_validator_unit_test;

   localparam int STALL_LIMIT     = 5000;
   localparam int HOLD_CYCLES     = 400;
   localparam int PHASE_BYTES     = 125;
   localparam int PHASES          = 8;
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   localparam mhv_pkg::hdr_type HDR_GOOD = mhv_pkg::hdr_type'{magic: 32'h0, version: 16'h1,
      msg_type: 16'h1, flags: 32'hFFFF_FFFF, request_id: 32'h8000_0001,
      metadata_length: 32'h0, body_length: 32'h0};
   localparam mhv_pkg::cfg_type CFG_MAX = mhv_pkg::cfg_type'{magic_word: 32'hFFFF_FFFF,
      protocol_version: 16'hFFFF, type_min: 16'h0, type_max: 16'hFFFF,
      metadata_limit: 32'hFFFF_FFFF, body_limit: 32'hFFFF_FFFF};

   typedef struct {
      bit               reconfig;
      mhv_pkg::cfg_type cfg;
      int               len;
      mhv_pkg::hdr_type hdr;
      bit               typed;
      mhv_pkg::rsp_type known_status;
   } header_case_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           push = 1'b0;
   logic                           full;
   logic [7:0]                     req_data_byte = '0;
   logic                           req_last = 1'b0;
   logic                           empty;
   logic                           pop = 1'b0;
   logic [2:0]                     rsp_status;
   logic [15:0]                    rsp_version;
   logic [15:0]                    rsp_msg_type;
   logic [31:0]                    rsp_flags;
   logic [31:0]                    rsp_request_id;
   logic [31:0]                    rsp_metadata_length;
   logic [31:0]                    rsp_body_length;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [mhv_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [mhv_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [mhv_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   // shadow of the block: header bytes, byte count and registers
   logic [7:0]       hdr_bytes [mhv_pkg::HEADER_BYTES];
   int               hdr_count = 0;
   mhv_pkg::cfg_type csr_shadow;

   mhv_pkg::rsp_type pending_status [$];
   int               fail_count = 0;
   int               idle_pct = 0;
   int               stall_pct = 0;
   int               hold_left = 0;
   int               quiet_cycles = 0;

   message_header_validator_unit dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data_byte(req_data_byte), .req_last(req_last),
      .empty(empty), .pop(pop),
      .rsp_status(rsp_status), .rsp_version(rsp_version), .rsp_msg_type(rsp_msg_type),
      .rsp_flags(rsp_flags), .rsp_request_id(rsp_request_id),
      .rsp_metadata_length(rsp_metadata_length), .rsp_body_length(rsp_body_length),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic mhv_pkg::rsp_type status_only(mhv_pkg::status_type s);
      mhv_pkg::rsp_type r;
      r = '0;
      r.status = s;
      return r;
   endfunction

   function automatic header_case_type header_case(bit reconfig, mhv_pkg::cfg_type c, int len,
                                                   mhv_pkg::hdr_type h, bit typed,
                                                   mhv_pkg::rsp_type k);
      header_case_type hc;
      hc.reconfig = reconfig;
      hc.cfg = c;
      hc.len = len;
      hc.hdr = h;
      hc.typed = typed;
      hc.known_status = k;
      return hc;
   endfunction

   function automatic void write_shadow(logic [2:0] idx, logic [31:0] v);
      case (idx)
         mhv_pkg::REG_MAGIC_WORD:       csr_shadow.magic_word = v;
         mhv_pkg::REG_PROTOCOL_VERSION: csr_shadow.protocol_version = v[15:0];
         mhv_pkg::REG_TYPE_MIN:         csr_shadow.type_min = v[15:0];
         mhv_pkg::REG_TYPE_MAX:         csr_shadow.type_max = v[15:0];
         mhv_pkg::REG_METADATA_LIMIT:   csr_shadow.metadata_limit = v;
         mhv_pkg::REG_BODY_LIMIT:       csr_shadow.body_limit = v;
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] shadow_value(logic [2:0] idx);
      case (idx)
         mhv_pkg::REG_MAGIC_WORD:       return csr_shadow.magic_word;
         mhv_pkg::REG_PROTOCOL_VERSION: return {16'h0, csr_shadow.protocol_version};
         mhv_pkg::REG_TYPE_MIN:         return {16'h0, csr_shadow.type_min};
         mhv_pkg::REG_TYPE_MAX:         return {16'h0, csr_shadow.type_max};
         mhv_pkg::REG_METADATA_LIMIT:   return csr_shadow.metadata_limit;
         mhv_pkg::REG_BODY_LIMIT:       return csr_shadow.body_limit;
         default:                       return '0;
      endcase
   endfunction

   // take one byte into the shadow; returns 1 when a status item falls due
   function automatic bit decode_byte(logic [7:0] b, logic l, output mhv_pkg::rsp_type r);
      logic [mhv_pkg::HDR_W-1:0] flat;
      mhv_pkg::hdr_type          h;
      mhv_pkg::status_type       s;
      r = '0;
      if (hdr_count < mhv_pkg::HEADER_BYTES) begin
         hdr_bytes[hdr_count] = b;
         hdr_count++;
      end
      if (!l) return 1'b0;
      if (hdr_count < mhv_pkg::HEADER_BYTES) begin
         r.status = mhv_pkg::STATUS_TRUNCATED;
      end else begin
         for (int i = 0; i < mhv_pkg::HEADER_BYTES; i++)
            flat[mhv_pkg::HDR_W-1-8*i -: 8] = hdr_bytes[i];
         h = mhv_pkg::hdr_type'(flat);
         if (h.magic != csr_shadow.magic_word) s = mhv_pkg::STATUS_BAD_MAGIC;
         else if (h.version != csr_shadow.protocol_version) s = mhv_pkg::STATUS_BAD_VERSION;
         else if (h.msg_type < csr_shadow.type_min || h.msg_type > csr_shadow.type_max)
            s = mhv_pkg::STATUS_UNKNOWN_TYPE;
         else if (h.metadata_length > csr_shadow.metadata_limit) s = mhv_pkg::STATUS_META_BIG;
         else if (h.body_length > csr_shadow.body_limit) s = mhv_pkg::STATUS_BODY_BIG;
         else s = mhv_pkg::STATUS_OK;
         r.status = s;
         if (s == mhv_pkg::STATUS_OK) begin
            r.version = h.version;
            r.msg_type = h.msg_type;
            r.flags = h.flags;
            r.request_id = h.request_id;
            r.metadata_length = h.metadata_length;
            r.body_length = h.body_length;
         end
      end
      hdr_count = 0;
      return 1'b1;
   endfunction

   function automatic logic [31:0] pick_within(logic [31:0] limit);
      if ($urandom_range(0, 3) == 0) return limit;
      if (limit == 32'hFFFF_FFFF) return $urandom;
      return $urandom_range(0, limit);
   endfunction

   function automatic logic [31:0] pick_above(logic [31:0] limit);
      if (limit == 32'hFFFF_FFFF) return $urandom;
      if ($urandom_range(0, 1) == 0) return limit + 32'd1;
      return $urandom_range(limit + 32'd1, 32'hFFFF_FFFF);
   endfunction

   function automatic mhv_pkg::cfg_type random_cfg();
      mhv_pkg::cfg_type c;
      c.magic_word = $urandom;
      c.protocol_version = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0) begin
         c.type_min = 16'($urandom_range(0, 65535));
         c.type_max = 16'($urandom_range(0, 65535));
      end else begin
         c.type_min = 16'($urandom_range(0, 60000));
         c.type_max = c.type_min + 16'($urandom_range(0, 5000));
      end
      c.metadata_limit = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 255);
      c.body_limit = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 255);
      return c;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // offer one item and hold it until taken; push stays high for a following item
   task automatic send_byte(logic [7:0] b, logic l);
      while ($urandom_range(0, 99) < idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data_byte <= b;
      req_last <= l;
      do @(posedge clock); while (full);
   endtask

   task automatic send_message(mhv_pkg::hdr_type h, int len, bit typed, mhv_pkg::rsp_type k);
      logic [mhv_pkg::HDR_W-1:0] flat;
      logic [7:0]                b;
      mhv_pkg::rsp_type          r;
      flat = h;
      for (int i = 0; i < len; i++) begin
         b = (i < mhv_pkg::HEADER_BYTES) ? flat[mhv_pkg::HDR_W-1-8*i -: 8]
                                         : 8'($urandom_range(0, 255));
         send_byte(b, i == len - 1);
         if (decode_byte(b, i == len - 1, r)) pending_status.push_back(typed ? k : r);
      end
   endtask

   task automatic send_random_message(output int len);
      mhv_pkg::hdr_type          h;
      logic [mhv_pkg::HDR_W-1:0] flat;
      int                        kind;
      int                        pick;
      kind = $urandom_range(0, 12);
      h.magic = csr_shadow.magic_word;
      h.version = csr_shadow.protocol_version;
      pick = $urandom_range(0, 2);
      if (pick == 0) h.msg_type = csr_shadow.type_min;
      else if (pick == 1) h.msg_type = csr_shadow.type_max;
      else h.msg_type = 16'($urandom_range(csr_shadow.type_min, csr_shadow.type_max));
      h.flags = $urandom;
      h.request_id = $urandom;
      h.metadata_length = pick_within(csr_shadow.metadata_limit);
      h.body_length = pick_within(csr_shadow.body_limit);
      case (kind)
         7:  h.magic ^= 32'h1 << $urandom_range(0, 31);
         8:  h.version ^= 16'($urandom_range(1, 65535));
         9:  h.msg_type = 16'($urandom_range(0, 65535));
         10: h.metadata_length = pick_above(csr_shadow.metadata_limit);
         11: h.body_length = pick_above(csr_shadow.body_limit);
         12: begin
            for (int i = 0; i < mhv_pkg::HEADER_BYTES; i++)
               flat[mhv_pkg::HDR_W-1-8*i -: 8] = 8'($urandom);
            h = mhv_pkg::hdr_type'(flat);
         end
         default: ;
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) len = $urandom_range(1, mhv_pkg::HEADER_BYTES - 1);
      else if (pick == 1) len = $urandom_range(mhv_pkg::HEADER_BYTES + 1, 40);
      else len = mhv_pkg::HEADER_BYTES;
      send_message(h, len, 1'b0, '0);
   endtask

   task automatic csr_access(logic wr, logic [2:0] idx, logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // drop push and let the block run dry before touching registers
   task automatic drain();
      push <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(mhv_pkg::cfg_type c);
      logic [31:0] vals [6];
      logic [2:0]  idxs [6];
      logic [31:0] rd;
      idxs = '{mhv_pkg::REG_MAGIC_WORD, mhv_pkg::REG_PROTOCOL_VERSION, mhv_pkg::REG_TYPE_MIN,
               mhv_pkg::REG_TYPE_MAX, mhv_pkg::REG_METADATA_LIMIT, mhv_pkg::REG_BODY_LIMIT};
      vals = '{c.magic_word, {16'h0, c.protocol_version}, {16'h0, c.type_min},
               {16'h0, c.type_max}, c.metadata_limit, c.body_limit};
      drain();
      foreach (idxs[i]) begin
         csr_access(1'b1, idxs[i], vals[i], rd);
         write_shadow(idxs[i], vals[i]);
      end
      // writes past the last register must leave everything alone
      csr_access(1'b1, REG_SPARE_LO, $urandom, rd);
      csr_access(1'b1, REG_SPARE_HI, $urandom, rd);
      foreach (idxs[i]) begin
         csr_access(1'b0, idxs[i], '0, rd);
         check_field($sformatf("register %0d", idxs[i]), shadow_value(idxs[i]), rd);
      end
   endtask

   // result side: check the taken item, then decide on pop for the next edge
   initial begin
      mhv_pkg::rsp_type want;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            if (pending_status.size() == 0) begin
               $error("status item 0x%0h with nothing outstanding", rsp_status);
               fail_count++;
            end else begin
               want = pending_status.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("version", 32'(want.version), 32'(rsp_version));
               check_field("msg_type", 32'(want.msg_type), 32'(rsp_msg_type));
               check_field("flags", want.flags, rsp_flags);
               check_field("request_id", want.request_id, rsp_request_id);
               check_field("metadata_length", want.metadata_length, rsp_metadata_length);
               check_field("body_length", want.body_length, rsp_body_length);
            end
         end
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else begin
            pop <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty) || (psel && penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      header_case_type  dir_table [$];
      mhv_pkg::hdr_type h;
      mhv_pkg::cfg_type c;
      mhv_pkg::rsp_type all_ones;
      int               sent;
      int               n;

      csr_shadow = mhv_pkg::cfg_type'{magic_word: 32'h0, protocol_version: 16'h1,
         type_min: 16'h1, type_max: 16'h1, metadata_limit: 32'h0, body_limit: 32'h0};
      all_ones = '1;
      all_ones.status = mhv_pkg::STATUS_OK;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers first: magic 0, version 1, type 1..1, limits 0
      dir_table.push_back(header_case(0, '0, 1, '0, 1,
                                      status_only(mhv_pkg::STATUS_TRUNCATED)));
      dir_table.push_back(header_case(0, '0, 23, '1, 1,
                                      status_only(mhv_pkg::STATUS_TRUNCATED)));
      dir_table.push_back(header_case(0, '0, 24, '0, 1,
                                      status_only(mhv_pkg::STATUS_BAD_VERSION)));
      dir_table.push_back(header_case(0, '0, 24, '1, 1,
                                      status_only(mhv_pkg::STATUS_BAD_MAGIC)));
      dir_table.push_back(header_case(0, '0, 24, HDR_GOOD, 0, '0));
      h = HDR_GOOD;
      h.msg_type = 16'h2;
      dir_table.push_back(header_case(0, '0, 24, h, 1,
                                      status_only(mhv_pkg::STATUS_UNKNOWN_TYPE)));
      h.msg_type = 16'h0;
      dir_table.push_back(header_case(0, '0, 24, h, 1,
                                      status_only(mhv_pkg::STATUS_UNKNOWN_TYPE)));
      h = HDR_GOOD;
      h.metadata_length = 32'h1;
      dir_table.push_back(header_case(0, '0, 24, h, 1,
                                      status_only(mhv_pkg::STATUS_META_BIG)));
      h = HDR_GOOD;
      h.body_length = 32'hFFFF_FFFF;
      dir_table.push_back(header_case(0, '0, 24, h, 1,
                                      status_only(mhv_pkg::STATUS_BODY_BIG)));
      // long message: trailing bytes are ignored, count holds at the header size
      dir_table.push_back(header_case(0, '0, 48, HDR_GOOD, 0, '0));
      h = HDR_GOOD;
      h.request_id = 32'h0;
      dir_table.push_back(header_case(0, '0, 24, h, 0, '0));
      dir_table.push_back(header_case(1, CFG_MAX, 24, '1, 1, all_ones));
      h = '1;
      h.magic = 32'h0;
      dir_table.push_back(header_case(0, '0, 24, h, 1,
                                      status_only(mhv_pkg::STATUS_BAD_MAGIC)));
      // empty type range: every type is unknown
      c = CFG_MAX;
      c.type_min = 16'hFFFF;
      c.type_max = 16'h0;
      dir_table.push_back(header_case(1, c, 24, '1, 1,
                                      status_only(mhv_pkg::STATUS_UNKNOWN_TYPE)));
      dir_table.push_back(header_case(0, '0, 30, '0, 1,
                                      status_only(mhv_pkg::STATUS_BAD_MAGIC)));

      foreach (dir_table[i]) begin
         if (dir_table[i].reconfig) apply_config(dir_table[i].cfg);
         send_message(dir_table[i].hdr, dir_table[i].len, dir_table[i].typed,
                      dir_table[i].known_status);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) c = '0;
         else if (phase == 1) c = CFG_MAX;
         else c = random_cfg();
         apply_config(c);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 67; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 67; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         // hold the result side off while items keep coming, to back the block up
         if (phase == 4) hold_left = HOLD_CYCLES;
         sent = 0;
         while (sent < PHASE_BYTES) begin
            send_random_message(n);
            sent += n;
         end
      end

      push <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
